@@ src/b32e_pkg.sv @@
// Package for the base32 stream encoder: job record passed from front to back,
// queue sizing, alphabet lookup. No dependencies.
package b32e_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [2:0] POS_LAST = 3'd4;

  // One classified byte: its symbols, optional flush symbol, final step, end mark.
  typedef struct packed {
    logic [4:0] sym0;
    logic [4:0] sym1;
    logic       two_sym;
    logic [4:0] flush_sym;
    logic       flush_en;
    logic [2:0] final_step;
    logic       last;
  } job_t;

  // RFC 4648 alphabet: A-Z then 2-7.
  function automatic logic [7:0] b32_char(input logic [4:0] v);
    logic [7:0] c;
    if (v < 5'd26) begin
      c = 8'h41 + {3'b000, v};
    end else begin
      c = 8'h32 + {3'b000, v - 5'd26};
    end
    return c;
  endfunction

endpackage

@@ src/b32e_front.sv @@
// Front end: accepts bytes, tracks group position and leftover bits, builds jobs.
// Depends on b32e_pkg.
module b32e_front import b32e_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [3:0] lo_q, lo_d;
  logic [2:0] pos_q, pos_d;
  logic [2:0] pos;
  logic [3:0] lo_new;
  logic [2:0] pads;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;
  assign pos        = (pos_q > POS_LAST) ? 3'd0 : pos_q;

  always_comb begin
    job_o         = '0;
    lo_new        = '0;
    pads          = '0;
    job_o.last    = last_byte_i;
    unique case (pos)
      3'd0: begin
        job_o.sym0      = data_byte_i[7:3];
        lo_new          = {1'b0, data_byte_i[2:0]};
        job_o.flush_sym = {data_byte_i[2:0], 2'b00};
        pads            = 3'd6;
      end
      3'd1: begin
        job_o.sym0      = {lo_q[2:0], data_byte_i[7:6]};
        job_o.sym1      = data_byte_i[5:1];
        job_o.two_sym   = 1'b1;
        lo_new          = {3'b000, data_byte_i[0]};
        job_o.flush_sym = {data_byte_i[0], 4'b0000};
        pads            = 3'd4;
      end
      3'd2: begin
        job_o.sym0      = {lo_q[0], data_byte_i[7:4]};
        lo_new          = data_byte_i[3:0];
        job_o.flush_sym = {data_byte_i[3:0], 1'b0};
        pads            = 3'd3;
      end
      3'd3: begin
        job_o.sym0      = {lo_q[3:0], data_byte_i[7]};
        job_o.sym1      = data_byte_i[6:2];
        job_o.two_sym   = 1'b1;
        lo_new          = {2'b00, data_byte_i[1:0]};
        job_o.flush_sym = {data_byte_i[1:0], 3'b000};
        pads            = 3'd1;
      end
      default: begin
        job_o.sym0      = {lo_q[1:0], data_byte_i[7:5]};
        job_o.sym1      = data_byte_i[4:0];
        job_o.two_sym   = 1'b1;
      end
    endcase
    job_o.flush_en   = last_byte_i && (pos != POS_LAST);
    // final step = symbols - 1, plus the flush and pads when flushing
    job_o.final_step = {2'b00, job_o.two_sym}
                     + (job_o.flush_en ? (pads + 3'd1) : 3'd0);
  end

  always_comb begin
    lo_d  = lo_q;
    pos_d = pos_q;
    if (push_o) begin
      if (last_byte_i) begin
        lo_d  = '0;
        pos_d = '0;
      end else begin
        lo_d  = lo_new;
        pos_d = (pos == POS_LAST) ? 3'd0 : pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q  <= '0;
      pos_q <= '0;
    end else begin
      lo_q  <= lo_d;
      pos_q <= pos_d;
    end
  end

endmodule

@@ src/b32e_queue.sv @@
// Short job queue between front and back.
// Depends on b32e_pkg.
module b32e_queue import b32e_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

endmodule

@@ src/b32e_back.sv @@
// Back end: walks a job one character per cycle into the output register while the output is not stalled.
// Depends on b32e_pkg.
module b32e_back import b32e_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  logic [2:0] step_q, step_d;
  logic       valid_q;
  logic [7:0] char_q;
  logic       last_q;
  logic       emit, at_end;
  logic [7:0] char_d;
  logic [2:0] flush_step;

  assign emit       = q_valid_i && (!valid_q || out_ready_i);
  assign at_end     = (step_q == job_i.final_step);
  assign pop_o      = emit && at_end;
  assign flush_step = job_i.two_sym ? 3'd2 : 3'd1;

  always_comb begin
    if (step_q == 3'd0) begin
      char_d = b32_char(job_i.sym0);
    end else if (step_q == 3'd1 && job_i.two_sym) begin
      char_d = b32_char(job_i.sym1);
    end else if (job_i.flush_en && step_q == flush_step) begin
      char_d = b32_char(job_i.flush_sym);
    end else begin
      char_d = PAD_CHAR;
    end
  end

  always_comb begin
    step_d = step_q;
    if (pop_o) begin
      step_d = '0;
    end else if (emit) begin
      step_d = step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (emit) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= char_d;
      last_q <= job_i.last && at_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

endmodule

@@ src/base32_stream_encoder.sv @@
// Top level of the base32 stream encoder: front end, job queue, back end.
// Depends on b32e_pkg, b32e_front, b32e_queue, b32e_back.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, data_byte_i, last_byte_i | request in
//   out     | out_valid_o, out_ready_i, out_char_o, out_last_o | request out
//
// Flow: a byte request is classified and queued in the cycle it is accepted;
// the back end then emits one character per cycle unless the output stalls or
// the queue is empty. A byte yields 1 or 2 characters (8 per five-byte group,
// 1.6 on average), a final byte up to 8; a single output register sets that rate.
// Reset clears group position, leftover bits, queue pointers and output valid.
// Stalls: the two-entry queue lets the input keep going while the output
// waits, and the input stalls only when the queue is full.
module base32_stream_encoder import b32e_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  logic push, pop, q_full, q_valid;
  job_t job_in, job_out;

  // Classify bytes and track group state.
  b32e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (job_in)
  );

  // Hold classified jobs so each side can stall on its own.
  b32e_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (job_out)
  );

  // Emit characters, flush and padding.
  b32e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o)
  );

endmodule

@@ verif/b32e_tb_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard for the base32 stream encoder testbench: it predicts the characters of each
// accepted byte and checks returned characters in order. Depends on b32e_pkg.
package b32e_tb_pkg;
  import b32e_pkg::*;

  localparam logic [255:0] B32_ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] code;
    logic       fin;
  } enc_char_t;

  class b32e_scoreboard;
    logic [3:0]  left_bits;
    logic [2:0]  grp_pos;
    enc_char_t   pending_chars[$];
    int unsigned n_bytes;
    int unsigned n_msgs;
    int unsigned n_chars;
    int unsigned n_errors;

    function new();
      left_bits = '0;
      grp_pos   = '0;
      n_bytes   = 0;
      n_msgs    = 0;
      n_chars   = 0;
      n_errors  = 0;
    endfunction

    function void push_char(logic [7:0] code);
      enc_char_t c;
      c.code = code;
      c.fin  = 1'b0;
      pending_chars.push_back(c);
    endfunction

    function void push_sym(logic [4:0] v);
      push_char(B32_ALPHABET[8 * (31 - int'(v)) +: 8]);
    endfunction

    // Predict the characters caused by one accepted byte request.
    function void note_byte(logic [7:0] b, logic fin);
      logic [2:0] p;
      logic [3:0] nxt_left;
      logic [4:0] flush;
      int         pads;
      enc_char_t  tail;
      p = (grp_pos > POS_LAST) ? 3'd0 : grp_pos;
      n_bytes++;
      case (p)
        3'd0: begin
          push_sym(b[7:3]);
          nxt_left = {1'b0, b[2:0]};
          flush    = {b[2:0], 2'b00};
          pads     = 6;
        end
        3'd1: begin
          push_sym({left_bits[2:0], b[7:6]});
          push_sym(b[5:1]);
          nxt_left = {3'b000, b[0]};
          flush    = {b[0], 4'b0000};
          pads     = 4;
        end
        3'd2: begin
          push_sym({left_bits[0], b[7:4]});
          nxt_left = b[3:0];
          flush    = {b[3:0], 1'b0};
          pads     = 3;
        end
        3'd3: begin
          push_sym({left_bits[3:0], b[7]});
          push_sym(b[6:2]);
          nxt_left = {2'b00, b[1:0]};
          flush    = {b[1:0], 3'b000};
          pads     = 1;
        end
        default: begin
          push_sym({left_bits[1:0], b[7:5]});
          push_sym(b[4:0]);
          nxt_left = '0;
          flush    = '0;
          pads     = 0;
        end
      endcase
      if (fin) begin
        if (p != POS_LAST) begin
          push_sym(flush);
          repeat (pads) push_char(PAD_CHAR);
        end
        tail     = pending_chars.pop_back();
        tail.fin = 1'b1;
        pending_chars.push_back(tail);
        left_bits = '0;
        grp_pos   = '0;
        n_msgs++;
      end else begin
        left_bits = nxt_left;
        grp_pos   = (p == POS_LAST) ? 3'd0 : p + 3'd1;
      end
    endfunction

    function void flag(string msg);
      n_errors++;
      if (n_errors <= REPORT_LIMIT) $display("mismatch: %s", msg);
    endfunction

    // Compare one returned character with the oldest prediction.
    function void check_char(logic [7:0] code, logic fin);
      enc_char_t want;
      n_chars++;
      if (pending_chars.size() == 0) begin
        flag($sformatf("unexpected character 0x%02h last=%0b", code, fin));
        return;
      end
      want = pending_chars.pop_front();
      if (want.code !== code || want.fin !== fin) begin
        flag($sformatf("character %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                       n_chars, want.code, want.fin, code, fin));
      end
    endfunction
  endclass

endpackage

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the base32 stream encoder testbench: clock, reset, request drivers, output monitor.
// Depends on b32e_pkg, b32e_tb_pkg and base32_stream_encoder.
module tb_top;
  import b32e_pkg::*;
  import b32e_tb_pkg::*;

  localparam int unsigned RAND_ITEMS   = 208;  // directed part adds 22 more
  localparam int unsigned QUIET_TAIL   = 40;   // last bytes run with no idling
  localparam int unsigned HOLD_AT      = 60;
  localparam int unsigned DRAIN_AT     = 120;
  localparam int unsigned LONG_HOLD    = 60;
  localparam int unsigned SETTLE_CYCLES = 20;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_char_o;
  logic       out_last_o;

  b32e_scoreboard sb = new();

  // Idling switch and long hold-off handshake between the main flow and the receiver.
  bit          idle_on   = 1'b0;
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int unsigned stall_left = 0;
  int unsigned rand_sent = 0;
  logic [7:0]  msg_q[$];

  base32_stream_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: hold ready low for a long stretch when asked, else in random short bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen   = hold_req;
      stall_left  = LONG_HOLD - 1;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left  = $urandom_range(1, 8) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: check every character request taken by the receiver.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_char(out_char_o, out_last_o);
  end

  // Offer one byte request, with an optional idle burst first, and hold it until taken.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b, fin);
  endtask

  // Send the bytes held in msg_q as one message, marking the final one.
  task automatic send_msg();
    int n;
    n = msg_q.size();
    for (int i = 0; i < n; i++) send_byte(msg_q[i], i == n - 1);
    msg_q.delete();
  endtask

  // Drop valid and wait until every predicted character has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_chars.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0:       b = 8'h00;
      1:       b = 8'hFF;
      2:       b = 8'h01 << $urandom_range(0, 7);
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  initial begin
    int unsigned len;
    bit          hold_done;
    bit          drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a final byte at each group position, all-zero and all-one bytes,
    // single set bits walking across positions, and a message spilling into a second group.
    msg_q = '{8'h00};                                    send_msg();
    msg_q = '{8'hFF};                                    send_msg();
    msg_q = '{8'hFF, 8'h00};                             send_msg();
    msg_q = '{8'h00, 8'hFF, 8'h80};                      send_msg();
    msg_q = '{8'h01, 8'h02, 8'h04, 8'h08};               send_msg();
    msg_q = '{8'h10, 8'h20, 8'h40, 8'h80, 8'hFF};        send_msg();
    msg_q = '{8'h66, 8'h6F, 8'h6F, 8'h62, 8'h61, 8'h72}; send_msg();
    drain();
    @(posedge clk_i);

    // Random part: messages of random length and content, mostly short, some long.
    idle_on = 1'b1;
    while (rand_sent < RAND_ITEMS) begin
      if (rand_sent >= RAND_ITEMS - QUIET_TAIL) idle_on = 1'b0;
      if (!hold_done && rand_sent >= HOLD_AT) begin
        // Keep offering bytes while the output is held off, so the queue fills.
        hold_req++;
        hold_done = 1'b1;
      end
      if (!drain_done && rand_sent >= DRAIN_AT) begin
        drain();
        drain_done = 1'b1;
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 12);
      if (len > RAND_ITEMS - rand_sent) len = RAND_ITEMS - rand_sent;
      repeat (len) msg_q.push_back(pick_byte());
      rand_sent += len;
      send_msg();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d bytes in %0d messages and %0d characters, with random gaps,",
             sb.n_bytes, sb.n_msgs, sb.n_chars);
    $display("one long output hold-off and one full drain; %0d mismatches, %0d left waiting.",
             sb.n_errors, sb.pending_chars.size());
    if (sb.n_errors == 0 && sb.pending_chars.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stop a hung run: far beyond the slowest legal run of this stimulus.
  initial begin
    #2_000_000;
    $display("timeout with %0d characters still waiting", sb.pending_chars.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
